[rtl/prk_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the Park rotation block: default widths, command codes,
// CORDIC gain correction and the arctangent table. No dependencies.
package prk_pkg;

    localparam int DATA_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;

    // fraction bits carried below the Q1.15 point through the CORDIC
    localparam int GUARD = 8;
    // residual angle, 2^32 units per turn, plus sign
    localparam int Z_WIDTH = 33;
    // 1/K in Q30
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    // atan(2^-i) in 2^32 units per turn, rounded
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] t;
        case (idx)
            0:       t = 32'h20000000;
            1:       t = 32'h12E4051E;
            2:       t = 32'h09FB385B;
            3:       t = 32'h051111D4;
            4:       t = 32'h028B0D43;
            5:       t = 32'h0145D7E1;
            6:       t = 32'h00A2F61E;
            7:       t = 32'h00517C55;
            8:       t = 32'h0028BE53;
            9:       t = 32'h00145F2F;
            10:      t = 32'h000A2F98;
            11:      t = 32'h000517CC;
            12:      t = 32'h00028BE6;
            13:      t = 32'h000145F3;
            14:      t = 32'h0000A2FA;
            15:      t = 32'h0000517D;
            16:      t = 32'h000028BE;
            17:      t = 32'h0000145F;
            18:      t = 32'h00000A30;
            19:      t = 32'h00000518;
            20:      t = 32'h0000028C;
            21:      t = 32'h00000146;
            22:      t = 32'h000000A3;
            23:      t = 32'h00000051;
            24:      t = 32'h00000029;
            25:      t = 32'h00000014;
            26:      t = 32'h0000000A;
            27:      t = 32'h00000005;
            28:      t = 32'h00000003;
            29:      t = 32'h00000001;
            30:      t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

[rtl/prk_cordic_stage.sv]
`timescale 1ns / 1ps
// One registered CORDIC micro-rotation (rotation mode) of the Park pipeline.
// Depends on prk_pkg for the arctangent table.
module prk_cordic_stage #(
    parameter int W    = 27,
    parameter int ZW   = 33,
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 up_valid,
    input  logic signed [W-1:0]  up_x,
    input  logic signed [W-1:0]  up_y,
    input  logic signed [ZW-1:0] up_z,
    output logic                 dn_valid,
    output logic signed [W-1:0]  dn_x,
    output logic signed [W-1:0]  dn_y,
    output logic signed [ZW-1:0] dn_z
);
    import prk_pkg::*;

    localparam logic signed [ZW-1:0] ANGLE_STEP =
        $signed(ZW'(atan_turn(STEP)));

    logic                 valid_reg;
    logic signed [W-1:0]  x_reg;
    logic signed [W-1:0]  y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [W-1:0]  x_next;
    logic signed [W-1:0]  y_next;
    logic signed [ZW-1:0] z_next;

    // arithmetic shifts floor, as required
    always_comb
    begin
        if (!up_z[ZW-1])
        begin
            x_next = up_x - (up_y >>> STEP);
            y_next = up_y + (up_x >>> STEP);
            z_next = up_z - ANGLE_STEP;
        end
        else
        begin
            x_next = up_x + (up_y >>> STEP);
            y_next = up_y - (up_x >>> STEP);
            z_next = up_z + ANGLE_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_x     = x_reg;
    assign dn_y     = y_reg;
    assign dn_z     = z_reg;

endmodule

[rtl/park_rotation.sv]
`timescale 1ns / 1ps
// Top level of the forward/inverse Park rotation: prescale, quadrant fold,
// CORDIC pipeline and rounding. Depends on prk_pkg and prk_cordic_stage.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | req_valid, req_stall | command, first_in, second_in, angle
//  result    | res_valid, res_stall | first_out, second_out
//
// Fully pipelined: one request per cycle unless the result is held, with one
// register stage per CORDIC micro-rotation plus multiply, fold and rounding
// stages.
// Reset clears only the stage valid bits; no clearing pass, no state.
// A held result (res_valid with res_stall) freezes every stage together, so
// req_stall follows it and nothing is dropped or duplicated.
module park_rotation #(
    parameter int DATA_WIDTH  = prk_pkg::DATA_WIDTH_DEF,
    parameter int ANGLE_WIDTH = prk_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         command,
    input  logic signed [DATA_WIDTH-1:0] first_in,
    input  logic signed [DATA_WIDTH-1:0] second_in,
    input  logic [ANGLE_WIDTH-1:0]       angle,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH:0]   first_out,
    output logic signed [DATA_WIDTH:0]   second_out
);
    import prk_pkg::*;

    localparam int CORDIC_STEPS = (DATA_WIDTH + 4 < 32) ? DATA_WIDTH + 4 : 32;
    // working width: Q1.15 plus guard bits plus headroom for gain and fold
    localparam int W  = DATA_WIDTH + GUARD + 3;
    // full product of a data word and the 31-bit signed gain constant
    localparam int PW = DATA_WIDTH + 31;
    localparam int SH = 30 - GUARD;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    localparam logic signed [PW-1:0] PRE_HALF  = PW'(64'sd1 <<< (SH - 1));
    localparam logic signed [W-1:0]  POST_HALF = W'(64'sd1 <<< (GUARD - 1));
    localparam logic signed [W-1:0]  SAT_HI = {{(W-DATA_WIDTH){1'b0}}, {DATA_WIDTH{1'b1}}};
    localparam logic signed [W-1:0]  SAT_LO = {{(W-DATA_WIDTH){1'b1}}, {DATA_WIDTH{1'b0}}};

    // single pipeline enable: everything moves unless the result is held
    logic en;
    assign en        = !(res_valid && res_stall);
    assign req_stall = !en;

    // ---- stage A: gain-correcting multiply, angle sign for forward mode
    logic                   a_valid_reg;
    logic signed [PW-1:0]   a_px_reg;
    logic signed [PW-1:0]   a_py_reg;
    logic [ANGLE_WIDTH-1:0] a_ang_reg;
    logic [ANGLE_WIDTH-1:0] a_ang_next;

    // forward rotates by -phi
    assign a_ang_next = (command == CMD_FORWARD) ? (~angle + ANGLE_WIDTH'(1)) : angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_px_reg  <= PW'(first_in)  * PW'($signed({1'b0, INV_GAIN_Q30}));
            a_py_reg  <= PW'(second_in) * PW'($signed({1'b0, INV_GAIN_Q30}));
            a_ang_reg <= a_ang_next;
        end
    end

    // ---- stage B: round to guard bits, exact quarter-turn fold
    logic signed [PW-1:0]  b_px_rnd;
    logic signed [PW-1:0]  b_py_rnd;
    logic signed [W-1:0]   b_x0;
    logic signed [W-1:0]   b_y0;
    logic signed [W-1:0]   b_x_next;
    logic signed [W-1:0]   b_y_next;
    logic signed [Z_WIDTH-1:0] b_z_next;
    logic                  b_valid_reg;
    logic signed [W-1:0]   b_x_reg;
    logic signed [W-1:0]   b_y_reg;
    logic signed [Z_WIDTH-1:0] b_z_reg;

    always_comb
    begin
        b_px_rnd = (a_px_reg + PRE_HALF) >>> SH;
        b_py_rnd = (a_py_reg + PRE_HALF) >>> SH;
        b_x0     = b_px_rnd[W-1:0];
        b_y0     = b_py_rnd[W-1:0];
        b_z_next = {3'b000, a_ang_reg[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
        case (a_ang_reg[ANGLE_WIDTH-1:ANGLE_WIDTH-2])
            QUAD_0:
            begin
                b_x_next = b_x0;
                b_y_next = b_y0;
            end
            QUAD_90:
            begin
                b_x_next = -b_y0;
                b_y_next = b_x0;
            end
            QUAD_180:
            begin
                b_x_next = -b_x0;
                b_y_next = -b_y0;
            end
            QUAD_270:
            begin
                b_x_next = b_y0;
                b_y_next = -b_x0;
            end
            default:
            begin
                b_x_next = b_x0;
                b_y_next = b_y0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_x_reg <= b_x_next;
            b_y_reg <= b_y_next;
            b_z_reg <= b_z_next;
        end
    end

    // ---- CORDIC micro-rotations, one register stage each
    logic [CORDIC_STEPS:0]      c_valid;
    logic signed [W-1:0]        c_x [0:CORDIC_STEPS];
    logic signed [W-1:0]        c_y [0:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0]  c_z [0:CORDIC_STEPS];

    assign c_valid[0] = b_valid_reg;
    assign c_x[0]     = b_x_reg;
    assign c_y[0]     = b_y_reg;
    assign c_z[0]     = b_z_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        prk_cordic_stage #(
            .W    (W),
            .ZW   (Z_WIDTH),
            .STEP (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (c_valid[i]),
            .up_x     (c_x[i]),
            .up_y     (c_y[i]),
            .up_z     (c_z[i]),
            .dn_valid (c_valid[i+1]),
            .dn_x     (c_x[i+1]),
            .dn_y     (c_y[i+1]),
            .dn_z     (c_z[i+1])
        );
    end

    // ---- final stage: drop guard bits with rounding, saturate (output register)
    logic signed [W-1:0]      f_x_rnd;
    logic signed [W-1:0]      f_y_rnd;
    logic signed [W-1:0]      f_x_sat;
    logic signed [W-1:0]      f_y_sat;
    logic                     res_valid_reg;
    logic signed [DATA_WIDTH:0] first_out_reg;
    logic signed [DATA_WIDTH:0] second_out_reg;

    always_comb
    begin
        f_x_rnd = (c_x[CORDIC_STEPS] + POST_HALF) >>> GUARD;
        f_y_rnd = (c_y[CORDIC_STEPS] + POST_HALF) >>> GUARD;
        if (f_x_rnd > SAT_HI)
            f_x_sat = SAT_HI;
        else if (f_x_rnd < SAT_LO)
            f_x_sat = SAT_LO;
        else
            f_x_sat = f_x_rnd;
        if (f_y_rnd > SAT_HI)
            f_y_sat = SAT_HI;
        else if (f_y_rnd < SAT_LO)
            f_y_sat = SAT_LO;
        else
            f_y_sat = f_y_rnd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= c_valid[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            first_out_reg  <= f_x_sat[DATA_WIDTH:0];
            second_out_reg <= f_y_sat[DATA_WIDTH:0];
        end
    end

    assign res_valid  = res_valid_reg;
    assign first_out  = first_out_reg;
    assign second_out = second_out_reg;

`ifndef SYNTHESIS
    // a free downstream never back-pressures the request side
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_stall |-> !req_stall)
        else $error("request stalled while result side is free");

    // a held result freezes the whole valid chain
    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=>
            ($stable(c_valid) && $stable(a_valid_reg) && $stable(res_valid)))
        else $error("pipeline moved while result held");

    // an accepted request occupies the first stage next cycle
    a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> a_valid_reg)
        else $error("accepted request lost at pipeline entry");
`endif

endmodule

[tb/sv/tb_park_rotation.sv]
`timescale 1ns / 1ps
// Self-checking bench for park_rotation: random and directed requests against
// a bit-exact CORDIC predictor, with random stalls and gaps on both channels.
// Depends on prk_pkg and the park_rotation RTL only.
module tb_park_rotation;

    import prk_pkg::*;

    localparam int DW       = DATA_WIDTH_DEF;
    localparam int AW       = ANGLE_WIDTH_DEF;
    localparam int STEPS    = DW + 4;         // micro-rotations in the CORDIC
    localparam int FRAC     = 8;              // guard bits below the Q1.15 point
    localparam int LATENCY  = STEPS + 3;
    localparam int LONG_HOLD = 200;           // receiver hold-off, in cycles
    localparam int LIMIT    = 1_000_000;      // cycles before we call it hung
    localparam int N_RANDOM = 1500;
    localparam longint RECIP_GAIN_Q30 = 64'sd652032874;

    // atan(2^-i) with 2^32 units per full turn, rounded
    localparam longint ATAN_STEP [0:19] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
    };

    typedef struct {
        logic                 cmd;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic [AW-1:0]        phi;
        logic signed [DW:0]   first;
        logic signed [DW:0]   second;
    } rotation_t;

    // Scoreboard: predicts each accepted request and checks results in order.
    class rotation_scoreboard;
        rotation_t pending_rotations[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // v * (1/K), kept with FRAC fraction bits, round half up
        function longint scale_down(logic signed [DW-1:0] v);
            longint p;
            p = longint'(v) * RECIP_GAIN_Q30 + (64'sd1 << (29 - FRAC));
            return p >>> (30 - FRAC);
        endfunction

        function logic signed [DW:0] round_out(longint v);
            longint r;
            r = (v + (64'sd1 << (FRAC - 1))) >>> FRAC;
            if (r > (64'sd1 << DW) - 1)
                r = (64'sd1 << DW) - 1;
            if (r < -(64'sd1 << DW))
                r = -(64'sd1 << DW);
            return r[DW:0];
        endfunction

        function void rotate_vector(ref rotation_t r);
            longint        xv, yv, zv, t, dx, dy;
            logic [AW-1:0] a;
            xv = scale_down(r.x);
            yv = scale_down(r.y);
            // forward rotation turns by -phi
            a = (r.cmd == CMD_INVERSE) ? r.phi : AW'(0) - r.phi;
            zv = longint'({a[AW-3:0], {(32 - AW){1'b0}}});
            case (a[AW-1:AW-2])
                2'd1: begin t = xv; xv = -yv; yv = t; end
                2'd2: begin xv = -xv; yv = -yv; end
                2'd3: begin t = xv; xv = yv; yv = -t; end
                default: ;
            endcase
            for (int i = 0; i < STEPS; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (zv >= 0)
                begin
                    xv -= dx;
                    yv += dy;
                    zv -= ATAN_STEP[i];
                end
                else
                begin
                    xv += dx;
                    yv -= dy;
                    zv += ATAN_STEP[i];
                end
            end
            r.first  = round_out(xv);
            r.second = round_out(yv);
        endfunction

        function void note_request(logic cmd, logic signed [DW-1:0] x,
                                   logic signed [DW-1:0] y, logic [AW-1:0] phi);
            rotation_t r;
            r.cmd = cmd;
            r.x   = x;
            r.y   = y;
            r.phi = phi;
            rotate_vector(r);
            pending_rotations.push_back(r);
        endfunction

        function void check_result(logic signed [DW:0] f, logic signed [DW:0] s);
            rotation_t want;
            if (pending_rotations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: first_out=%0d second_out=%0d", f, s);
                return;
            end
            want = pending_rotations.pop_front();
            if (want.first !== f || want.second !== s)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch cmd=%0b x=%0d y=%0d angle=%h: exp %0d/%0d got %0d/%0d",
                             want.cmd, want.x, want.y, want.phi,
                             want.first, want.second, f, s);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    logic                 command;
    logic signed [DW-1:0] first_in;
    logic signed [DW-1:0] second_in;
    logic [AW-1:0]        angle;
    logic                 res_valid;
    logic                 res_stall;
    logic signed [DW:0]   first_out;
    logic signed [DW:0]   second_out;

    rotation_scoreboard sb = new();

    // steady: both sides stop idling; long_hold: receiver freezes for LONG_HOLD
    bit steady    = 1'b0;
    bit long_hold = 1'b0;
    int cycles    = 0;

    // corner vectors and angles for the directed part
    logic signed [DW-1:0] probe_x [0:11] = '{-32768, 32767, -32768, 32767, 0, 16384,
                                             -1, 1, 32767, -32768, 12345, -20000};
    logic signed [DW-1:0] probe_y [0:11] = '{-32768, 32767, 32767, -32768, 0, -16384,
                                             -1, 32767, 0, 0, -23456, 30000};
    logic [AW-1:0]        probe_a [0:11] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                             16'hFFFF, 16'h0001, 16'h3FFF, 16'h2000,
                                             16'h7FFF, 16'hBFFF, 16'hE000, 16'h5555};

    park_rotation uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .command    (command),
        .first_in   (first_in),
        .second_in  (second_in),
        .angle      (angle),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .first_out  (first_out),
        .second_out (second_out)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_park_rotation NOT OK");
            $finish;
        end
    end

    // Result side is sampled at the rising edge; res_stall only moves on the
    // falling edge, so the pair seen here is what the block saw.
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(first_out, second_out);

    // Mostly short gaps, now and then a long one; none while steady.
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver: random stall runs, plus the long hold-off when asked for.
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        res_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                res_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                res_stall  <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    // Presents one request from the next falling edge and holds it until the
    // block takes it. Valid is left high so back-to-back requests need no dip.
    task automatic offer_rotation(input logic cmd, input logic signed [DW-1:0] x,
                                  input logic signed [DW-1:0] y, input logic [AW-1:0] phi);
        @(negedge clk);
        req_valid <= 1'b1;
        command   <= cmd;
        first_in  <= x;
        second_in <= y;
        angle     <= phi;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(cmd, x, y, phi);
    endtask

    // Sender idles with junk on the payload for as long as n asks; n == 0 skips it.
    task automatic sender_pause(input int n);
        if (n == 0)
            return;
        @(negedge clk);
        req_valid <= 1'b0;
        command   <= 1'($urandom_range(0, 1));
        first_in  <= DW'($urandom);
        second_in <= DW'($urandom);
        angle     <= AW'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    // Sender goes quiet until every outstanding result is back.
    task automatic drain_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_rotations.size() != 0)
            @(posedge clk);
    endtask

    // Data biased towards full scale and the values around zero.
    function automatic logic signed [DW-1:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            3:       return 0;
            default: return DW'($urandom);
        endcase
    endfunction

    // Angles: uniform, with some clustered on the quadrant seams.
    function automatic logic [AW-1:0] pick_angle();
        if ($urandom_range(0, 6) == 0)
            return AW'(($urandom_range(0, 3) << (AW - 2)) + $urandom_range(0, 4) - 2);
        return AW'($urandom);
    endfunction

    task automatic random_rotations(input int n);
        for (int i = 0; i < n; i++)
        begin
            offer_rotation($urandom_range(0, 1) ? CMD_INVERSE : CMD_FORWARD,
                           pick_sample(), pick_sample(), pick_angle());
            sender_pause(pick_gap());
        end
    endtask

    initial
    begin : stimulus
        rst_n     = 1'b0;
        req_valid = 1'b0;
        command   = CMD_FORWARD;
        first_in  = '0;
        second_in = '0;
        angle     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed corners: full-scale vectors, quadrant seams, both commands
        for (int k = 0; k < 24; k++)
        begin
            offer_rotation(k < 12 ? CMD_FORWARD : CMD_INVERSE,
                           probe_x[k % 12], probe_y[k % 12], probe_a[(k * 5) % 12]);
            sender_pause(pick_gap());
        end
        drain_results();

        // back-pressure: receiver freezes while the sender keeps pushing,
        // so the pipe fills and req_stall has to rise
        long_hold = 1'b1;
        steady    = 1'b1;
        random_rotations(80);
        steady    = 1'b0;

        random_rotations(N_RANDOM * 2 / 5);
        drain_results();

        // a stretch at full rate on both sides
        steady = 1'b1;
        random_rotations(N_RANDOM / 5);
        steady = 1'b0;

        random_rotations(N_RANDOM * 2 / 5);
        drain_results();

        // anything turning up now is a stray result
        repeat (4 * LATENCY) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_rotations.size() == 0)
            $display("tb_park_rotation OK");
        else
            $display("tb_park_rotation NOT OK");
        $finish;
    end

endmodule
